FILE: rtl/nds_pkg.sv
`default_nettype none
package nds_pkg;

    localparam int PITCH_W    = 7;
    localparam int VEL_W      = 7;
    localparam int DUR_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam int RESULT_CAP = 16;
    localparam int CNT_W      = $clog2(RESULT_CAP + 1);

    typedef enum logic [1:0] {
        MODE_NOTE  = 2'd0,
        MODE_TICK  = 2'd1,
        MODE_STOP  = 2'd2,
        MODE_CLEAR = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NOTE_VELOCITY = 1'd0,
        REG_NOTE_DURATION = 1'd1
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NOTE,
        ST_SCAN,
        ST_DRAIN,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic load;
        logic clear_all;
        logic note_step;
        logic scan_issue;
        logic flush;
    } nds_cmd_t;

    typedef struct packed {
        logic note_done;
        logic idx_last;
    } nds_status_t;

endpackage
`default_nettype wire

FILE: rtl/nds_ram.sv
`default_nettype none
module nds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/nds_ctrl.sv
`default_nettype none
module nds_ctrl
    import nds_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire mode_t       mode,
    input  wire nds_status_t status,
    output nds_cmd_t         cmd,
    output logic             busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load = 1'b1;
                    unique case (mode)
                        MODE_NOTE:  state_next = ST_NOTE;
                        MODE_TICK:  state_next = ST_SCAN;
                        MODE_STOP:  state_next = ST_SCAN;
                        MODE_CLEAR: cmd.clear_all = 1'b1;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_NOTE:
            begin
                cmd.note_step = 1'b1;
                if (status.note_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                if (status.idx_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            // last slot read is processed here
            ST_DRAIN:
            begin
                state_next = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                cmd.flush  = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: rtl/nds_datapath.sv
`default_nettype none
module nds_datapath
    import nds_pkg::*;
#(
    parameter int MAX_NOTES = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire nds_cmd_t              cmd,
    output nds_status_t                status,
    input  wire mode_t                 mode,
    input  wire logic [PITCH_W-1:0]    pitch,
    input  wire logic                  wr_en,
    input  wire logic [CFG_IDX_W-1:0]  wr_index,
    input  wire logic [CFG_DATA_W-1:0] wr_data,
    output logic                       result_valid,
    output logic [PITCH_W-1:0]         out_pitch,
    output logic [VEL_W-1:0]           out_velocity,
    output logic                       table_full,
    output logic                       last
);

    localparam int AW     = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
    localparam int SLOT_W = PITCH_W + DUR_W;

    logic [VEL_W-1:0]     vel_reg;
    logic [DUR_W-1:0]     dur_reg;
    mode_t                mode_reg;
    logic [PITCH_W-1:0]   pitch_reg;
    logic [MAX_NOTES-1:0] valid_reg, valid_next;
    logic [AW-1:0]        idx_reg, idx_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [PITCH_W-1:0]   pend_pitch_reg, pend_pitch_next;
    logic                 s2_valid_reg, s2_valid_next;
    logic [AW-1:0]        s2_idx_reg;
    logic                 out_valid_reg;
    logic [PITCH_W-1:0]   out_pitch_reg;
    logic [VEL_W-1:0]     out_vel_reg;
    logic                 out_full_reg;
    logic                 out_last_reg;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [SLOT_W-1:0]    ram_wdata;
    logic [SLOT_W-1:0]    ram_rdata;
    logic [PITCH_W-1:0]   rd_pitch;
    logic [DUR_W-1:0]     rd_rem;
    logic                 idx_at_last;
    logic                 take;
    logic                 emit;
    logic [PITCH_W-1:0]   emit_pitch;
    logic [VEL_W-1:0]     emit_vel;
    logic                 emit_full;
    logic                 emit_last;

    nds_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (MAX_NOTES)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign rd_pitch    = ram_rdata[SLOT_W-1:DUR_W];
    assign rd_rem      = ram_rdata[DUR_W-1:0];
    assign idx_at_last = (idx_reg == AW'(MAX_NOTES - 1));

    assign status.note_done = !valid_reg[idx_reg] || idx_at_last;
    assign status.idx_last  = idx_at_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vel_reg <= '0;
            dur_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx_t'(wr_index))
                REG_NOTE_VELOCITY: vel_reg <= wr_data[VEL_W-1:0];
                REG_NOTE_DURATION: dur_reg <= wr_data[DUR_W-1:0];
                default:           vel_reg <= vel_reg;
            endcase
        end
    end

    always_comb
    begin
        valid_next      = valid_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_pitch_next = pend_pitch_reg;
        s2_valid_next   = cmd.scan_issue;
        ram_we          = 1'b0;
        ram_waddr       = s2_idx_reg;
        ram_wdata       = {rd_pitch, rd_rem};
        take            = 1'b0;
        emit            = 1'b0;
        emit_pitch      = pend_pitch_reg;
        emit_vel        = '0;
        emit_full       = 1'b0;
        emit_last       = 1'b0;

        if (cmd.load)
        begin
            idx_next        = '0;
            cnt_next        = '0;
            pend_valid_next = 1'b0;
        end
        if (cmd.clear_all)
        begin
            valid_next = '0;
        end

        // search for the lowest free slot, one per cycle
        if (cmd.note_step)
        begin
            idx_next = idx_reg + 1'b1;
            if (!valid_reg[idx_reg])
            begin
                valid_next[idx_reg] = 1'b1;
                ram_we     = 1'b1;
                ram_waddr  = idx_reg;
                ram_wdata  = {pitch_reg, dur_reg};
                emit       = 1'b1;
                emit_pitch = pitch_reg;
                emit_vel   = vel_reg;
                emit_last  = 1'b1;
            end
            else if (idx_at_last)
            begin
                emit       = 1'b1;
                emit_pitch = pitch_reg;
                emit_vel   = vel_reg;
                emit_full  = 1'b1;
                emit_last  = 1'b1;
            end
        end

        if (cmd.scan_issue)
        begin
            idx_next = idx_reg + 1'b1;
        end

        // second scan stage: slot data is back from the RAM
        if (s2_valid_reg && valid_reg[s2_idx_reg])
        begin
            if (mode_reg == MODE_TICK)
            begin
                if (rd_rem <= DUR_W'(1))
                begin
                    if (cnt_reg < CNT_W'(RESULT_CAP))
                    begin
                        take = 1'b1;
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = {rd_pitch, {DUR_W{1'b0}}};
                    end
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_wdata = {rd_pitch, rd_rem - 1'b1};
                end
            end
            else if (mode_reg == MODE_STOP && cnt_reg < CNT_W'(RESULT_CAP))
            begin
                take = 1'b1;
            end
        end

        // hold each note-off until the next one is found so the final one can carry last
        if (take)
        begin
            valid_next[s2_idx_reg] = 1'b0;
            cnt_next               = cnt_reg + 1'b1;
            pend_valid_next        = 1'b1;
            pend_pitch_next        = rd_pitch;
            emit                   = pend_valid_reg;
        end

        if (cmd.flush && pend_valid_reg)
        begin
            emit            = 1'b1;
            emit_last       = 1'b1;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            s2_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            valid_reg      <= valid_next;
            idx_reg        <= idx_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            s2_valid_reg   <= s2_valid_next;
            out_valid_reg  <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_pitch_reg <= pend_pitch_next;
        s2_idx_reg     <= idx_reg;
        if (cmd.load)
        begin
            mode_reg  <= mode;
            pitch_reg <= pitch;
        end
        if (emit)
        begin
            out_pitch_reg <= emit_pitch;
            out_vel_reg   <= emit_vel;
            out_full_reg  <= emit_full;
            out_last_reg  <= emit_last;
        end
    end

    assign result_valid = out_valid_reg;
    assign out_pitch    = out_pitch_reg;
    assign out_velocity = out_vel_reg;
    assign table_full   = out_full_reg;
    assign last         = out_last_reg;

endmodule
`default_nettype wire

FILE: rtl/note_duration_scheduler.sv
// Note duration scheduler: turns pitches into note-on / note-off pairs.
// Input: an item is taken on a rising edge with start high and busy low.
//   mode 0 sends a note-on (pitch, note_velocity) and stores the note in the
//   lowest free slot for note_duration ticks; table_full flags a full table.
//   mode 1 counts slots down and sends velocity-0 note-offs for expired ones.
//   mode 2 sends note-offs for all active slots; mode 3 drops them silently.
// Output: each result shows for one cycle with result_valid high; last marks
//   the final result of an item. The receiver cannot stall the block.
// Config: wr_en/wr_index/wr_data write note_velocity (0) or note_duration (1)
//   at once; write only while busy is low.
// Sequence: a note item searches the slots from slot 0 upwards and stops at
//   the first free slot (the last slot when the table is full); its result
//   shows in the cycle after its last search step. Tick and stop items scan
//   one slot per cycle through the slot RAM read port, then pass a drain and
//   a flush state; each note-off is held until the next one is found, and the
//   final one shows in the cycle after the flush state. A clear item leaves
//   the block idle. At most 16 results come from one item.
// Reset: clears all slots and both registers; no clearing pass is needed.
`default_nettype none
module note_duration_scheduler
    import nds_pkg::*;
#(
    parameter int MAX_NOTES = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [1:0]            mode,
    input  wire logic [PITCH_W-1:0]    pitch,
    input  wire logic                  wr_en,
    input  wire logic [CFG_IDX_W-1:0]  wr_index,
    input  wire logic [CFG_DATA_W-1:0] wr_data,
    output logic                       result_valid,
    output logic [PITCH_W-1:0]         out_pitch,
    output logic [VEL_W-1:0]           out_velocity,
    output logic                       table_full,
    output logic                       last
);

    nds_cmd_t    cmd;
    nds_status_t status;
    mode_t       mode_in;

    assign mode_in = mode_t'(mode);

    nds_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .mode   (mode_in),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    nds_datapath #(
        .MAX_NOTES (MAX_NOTES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .mode         (mode_in),
        .pitch        (pitch),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .result_valid (result_valid),
        .out_pitch    (out_pitch),
        .out_velocity (out_velocity),
        .table_full   (table_full),
        .last         (last)
    );

endmodule
`default_nettype wire

FILE: dv/note_duration_scheduler_tb.sv
`default_nettype none
module note_duration_scheduler_tb;
    import nds_pkg::*;

    localparam int NOTE_SLOTS = 16;

    typedef struct {
        logic [PITCH_W-1:0] pitch;
        logic [VEL_W-1:0]   velocity;
        logic               full;
        logic               last;
    } note_event_t;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    logic [1:0]            mode;
    logic [PITCH_W-1:0]    pitch;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;
    logic                  result_valid;
    logic [PITCH_W-1:0]    out_pitch;
    logic [VEL_W-1:0]      out_velocity;
    logic                  table_full;
    logic                  last;

    // predicted block state
    logic [VEL_W-1:0]   sched_velocity = '0;
    logic [DUR_W-1:0]   sched_duration = '0;
    logic               slot_busy [NOTE_SLOTS];
    logic [PITCH_W-1:0] slot_note [NOTE_SLOTS];
    logic [DUR_W-1:0]   slot_ticks_left [NOTE_SLOTS];

    note_event_t note_events_due[$];
    note_event_t want;
    int          err_count = 0;
    bit          gaps_on = 1'b1;

    note_duration_scheduler #(.MAX_NOTES(NOTE_SLOTS)) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .pitch        (pitch),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data),
        .result_valid (result_valid),
        .out_pitch    (out_pitch),
        .out_velocity (out_velocity),
        .table_full   (table_full),
        .last         (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("note_duration_scheduler test failed");
        $finish;
    end

    task automatic push_event(logic [PITCH_W-1:0] p, logic [VEL_W-1:0] v, logic f);
        note_event_t ev;
        ev.pitch    = p;
        ev.velocity = v;
        ev.full     = f;
        ev.last     = 1'b0;
        note_events_due.push_back(ev);
    endtask

    // Work out the events one accepted item causes and update slot state.
    task automatic schedule_item(mode_t m, logic [PITCH_W-1:0] p);
        int n;
        int free_idx;
        n = 0;
        free_idx = -1;
        case (m)
            MODE_NOTE:
            begin
                for (int i = 0; i < NOTE_SLOTS; i++)
                begin
                    if (!slot_busy[i] && free_idx < 0)
                        free_idx = i;
                end
                if (free_idx >= 0)
                begin
                    slot_busy[free_idx]       = 1'b1;
                    slot_note[free_idx]       = p;
                    slot_ticks_left[free_idx] = sched_duration;
                end
                push_event(p, sched_velocity, free_idx < 0);
                n = 1;
            end
            MODE_TICK:
            begin
                for (int i = 0; i < NOTE_SLOTS; i++)
                begin
                    if (slot_busy[i])
                    begin
                        if (slot_ticks_left[i] <= 1)
                        begin
                            if (n < RESULT_CAP)
                            begin
                                push_event(slot_note[i], '0, 1'b0);
                                slot_busy[i] = 1'b0;
                                n++;
                            end
                            else
                                slot_ticks_left[i] = '0;  // hold until next tick
                        end
                        else
                            slot_ticks_left[i] = slot_ticks_left[i] - 1'b1;
                    end
                end
            end
            MODE_STOP:
            begin
                for (int i = 0; i < NOTE_SLOTS; i++)
                begin
                    if (slot_busy[i] && n < RESULT_CAP)
                    begin
                        push_event(slot_note[i], '0, 1'b0);
                        slot_busy[i] = 1'b0;
                        n++;
                    end
                end
            end
            default:
            begin
                for (int i = 0; i < NOTE_SLOTS; i++)
                    slot_busy[i] = 1'b0;
            end
        endcase
        if (n > 0)
            note_events_due[note_events_due.size() - 1].last = 1'b1;
    endtask

    // Track register writes and accepted items at the clock edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (wr_en)
            begin
                case (reg_idx_t'(wr_index))
                    REG_NOTE_VELOCITY: sched_velocity = wr_data[VEL_W-1:0];
                    REG_NOTE_DURATION: sched_duration = wr_data[DUR_W-1:0];
                    default: ;
                endcase
            end
            if (start && !busy)
                schedule_item(mode_t'(mode), pitch);
        end
    end

    task automatic log_mismatch(string what, note_event_t ev);
        err_count++;
        if (err_count <= 10)
            $display("%0t: %s: got pitch %0d vel %0d full %0b last %0b, want pitch %0d vel %0d full %0b last %0b",
                     $time, what, out_pitch, out_velocity, table_full, last,
                     ev.pitch, ev.velocity, ev.full, ev.last);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (note_events_due.size() == 0)
            begin
                want = '{default: '0};
                log_mismatch("unexpected event", want);
            end
            else
            begin
                want = note_events_due.pop_front();
                if (out_pitch !== want.pitch || out_velocity !== want.velocity ||
                    table_full !== want.full || last !== want.last)
                    log_mismatch("event mismatch", want);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 40);
    endfunction

    function automatic mode_t pick_mode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return MODE_NOTE;
        else if (r < 82)
            return MODE_TICK;
        else if (r < 91)
            return MODE_STOP;
        else
            return MODE_CLEAR;
    endfunction

    // Present one item and hold it until the block takes it; start stays high
    // when no gap follows so a back-to-back item is taken as soon as busy is low.
    task automatic send_item(mode_t m, logic [PITCH_W-1:0] p);
        int gap;
        start <= 1'b1;
        mode  <= m;
        pitch <= p;
        do
            @(posedge clk);
        while (busy);
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        wr_en    <= 1'b0;
        @(posedge clk);
    endtask

    // Wait out all pending events, plus a full slot scan for silent ticks.
    task automatic settle();
        start <= 1'b0;
        while (note_events_due.size() != 0)
            @(posedge clk);
        repeat (NOTE_SLOTS + 8) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic test_reset_state();
        send_item(MODE_NOTE, 7'd127);
        send_item(MODE_TICK, 7'd0);
        send_item(MODE_TICK, 7'd85);
        send_item(MODE_STOP, 7'd42);
        send_item(MODE_CLEAR, 7'd127);
        settle();
    endtask

    task automatic test_table_overflow();
        write_reg(REG_NOTE_VELOCITY, 16'd127);
        write_reg(REG_NOTE_DURATION, 16'd2);
        for (int i = 0; i < NOTE_SLOTS; i++)
            send_item(MODE_NOTE, (i == 0) ? 7'd0 :
                      (i == NOTE_SLOTS - 1) ? 7'd127 : 7'($urandom_range(0, 127)));
        send_item(MODE_NOTE, 7'($urandom_range(0, 127)));
        send_item(MODE_TICK, 7'd0);
        send_item(MODE_STOP, 7'd0);
        settle();
    endtask

    task automatic test_random_traffic();
        logic [VEL_W-1:0] vel;
        logic [DUR_W-1:0] dur;
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin vel = '0;      dur = 16'd0; end
                1: begin vel = 7'd127;  dur = 16'd1; end
                2: begin vel = 7'($urandom_range(0, 127)); dur = 16'd3; end
                3: begin vel = 7'($urandom_range(0, 127)); dur = 16'($urandom_range(2, 8)); end
                4: begin vel = 7'd127;  dur = 16'hFFFF; end
                default: begin vel = 7'($urandom_range(0, 127)); dur = 16'($urandom); end
            endcase
            gaps_on = (ph != 1 && ph != 3);
            settle();
            write_reg(REG_NOTE_VELOCITY, {9'd0, vel});
            write_reg(REG_NOTE_DURATION, dur);
            repeat (25)
                send_item(pick_mode(), 7'($urandom_range(0, 127)));
        end
        gaps_on = 1'b1;
        settle();
    endtask

    initial
    begin
        rst_n    = 1'b0;
        start    = 1'b0;
        mode     = '0;
        pitch    = '0;
        wr_en    = 1'b0;
        wr_index = '0;
        wr_data  = '0;
        for (int i = 0; i < NOTE_SLOTS; i++)
        begin
            slot_busy[i]       = 1'b0;
            slot_note[i]       = '0;
            slot_ticks_left[i] = '0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_table_overflow();
        test_random_traffic();

        while (note_events_due.size() != 0)
            @(posedge clk);
        repeat (NOTE_SLOTS + 12) @(posedge clk);
        if (err_count == 0 && note_events_due.size() == 0)
            $display("note_duration_scheduler test passed");
        else
            $display("note_duration_scheduler test failed");
        $finish;
    end

endmodule
`default_nettype wire
